### design/tstm_pkg.sv
// Shared types and constants for the touch sample trimmed-mean calibration block.
package tstm_pkg;

    localparam int ADC_BITS       = 12;
    localparam int SUM_W          = ADC_BITS + 4;
    localparam int COEF_W         = 32;
    localparam int SCR_W          = 16;
    localparam int PROD_W         = COEF_W + ADC_BITS + 1;
    localparam int ACC_W          = PROD_W + 2;
    localparam int COUNT_W        = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int AVG_SHIFT_DFLT = 3;
    localparam int COEF_FRAC_DFLT = 16;

    localparam logic [COUNT_W-1:0]  RUN_LEN = COUNT_W'(10);
    localparam logic [ADC_BITS-1:0] ADC_MAX = '1;
    localparam int SCR_MAX = 32767;
    localparam int SCR_MIN = -32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_X_AX = 3'd0,
        CFG_GAIN_X_AY = 3'd1,
        CFG_OFFSET_X  = 3'd2,
        CFG_GAIN_Y_AX = 3'd3,
        CFG_GAIN_Y_AY = 3'd4,
        CFG_OFFSET_Y  = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic [ADC_BITS-1:0] adc_x;
        logic [ADC_BITS-1:0] adc_y;
        logic                pen_down;
    } t_in_item;

    typedef struct packed {
        logic                    ok;
        logic [ADC_BITS-1:0]     avg_x;
        logic [ADC_BITS-1:0]     avg_y;
        logic signed [SCR_W-1:0] screen_x;
        logic signed [SCR_W-1:0] screen_y;
    } t_out_item;

    typedef struct packed {
        logic fire;
        logic first;
        logic restart;
    } t_axis_ctrl;

    typedef struct packed {
        logic [SUM_W-1:0]    sum;
        logic [ADC_BITS-1:0] lo;
        logic [ADC_BITS-1:0] hi;
    } t_axis_run;

    typedef struct packed {
        logic en_mul;
        logic en_out;
    } t_aff_ctrl;

endpackage

### design/touch_sample_trimmed_mean_calibrate_top.sv
// Top level of the touch sample trimmed-mean and affine calibration block.
// Throughput is one item per cycle unless the output stalls; the run accumulators update
// once per registered item. A run's result passes the input register, accumulate, mean,
// multiply and output stages, each of which an output stall can hold.
// Synchronous active-low reset clears the run state, the coefficients and all valid bits.
module touch_sample_trimmed_mean_calibrate_top
    import tstm_pkg::*;
#(
    parameter int AVG_SHIFT      = AVG_SHIFT_DFLT,
    parameter int COEF_FRAC_BITS = COEF_FRAC_DFLT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COEF_W-1:0]    i_cfg_data
);

    logic signed [COEF_W-1:0] r_gain_x_ax;
    logic signed [COEF_W-1:0] r_gain_x_ay;
    logic signed [COEF_W-1:0] r_offset_x;
    logic signed [COEF_W-1:0] r_gain_y_ax;
    logic signed [COEF_W-1:0] r_gain_y_ay;
    logic signed [COEF_W-1:0] r_offset_y;

    logic                r_a_v;
    t_in_item            r_a;
    logic [COUNT_W-1:0]  r_count;
    logic [COUNT_W-1:0]  n_count;
    logic                r_b_v;
    logic                r_b_ok;
    t_axis_run           r_b_x;
    t_axis_run           r_b_y;
    logic                r_c_v;
    logic                r_c_ok;
    logic [ADC_BITS-1:0] r_c_mx;
    logic [ADC_BITS-1:0] r_c_my;
    logic                r_d_v;
    logic                r_d_ok;
    logic [ADC_BITS-1:0] r_d_mx;
    logic [ADC_BITS-1:0] r_d_my;
    logic                r_e_v;
    logic                r_e_ok;
    logic [ADC_BITS-1:0] r_e_mx;
    logic [ADC_BITS-1:0] r_e_my;

    logic ready_a, ready_b, ready_c, ready_d, ready_e;
    logic a_fire, run_done, run_result;
    t_axis_ctrl axis_ctrl;
    t_axis_run  run_x, run_y;
    t_aff_ctrl  aff_ctrl;
    logic [ADC_BITS-1:0] mean_x, mean_y;
    logic signed [COEF_W-1:0] off_x, off_y;
    logic signed [SCR_W-1:0]  screen_x, screen_y;

    function automatic logic [ADC_BITS-1:0] trim_mean(input t_axis_run run);
        logic [SUM_W-1:0] diff;
        logic [SUM_W-1:0] shifted;
        diff    = run.sum - SUM_W'(run.lo) - SUM_W'(run.hi);
        shifted = diff >> AVG_SHIFT;
        if (shifted > SUM_W'(ADC_MAX)) begin
            return ADC_MAX;
        end
        return shifted[ADC_BITS-1:0];
    endfunction

    // Configuration.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_x_ax <= '0;
            r_gain_x_ay <= '0;
            r_offset_x  <= '0;
            r_gain_y_ax <= '0;
            r_gain_y_ay <= '0;
            r_offset_y  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_GAIN_X_AX: r_gain_x_ax <= i_cfg_data;
                CFG_GAIN_X_AY: r_gain_x_ay <= i_cfg_data;
                CFG_OFFSET_X:  r_offset_x  <= i_cfg_data;
                CFG_GAIN_Y_AX: r_gain_y_ax <= i_cfg_data;
                CFG_GAIN_Y_AY: r_gain_y_ay <= i_cfg_data;
                CFG_OFFSET_Y:  r_offset_y  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage flow control.
    assign ready_e    = !r_e_v || !i_out_stall;
    assign ready_d    = !r_d_v || ready_e;
    assign ready_c    = !r_c_v || ready_d;
    assign ready_b    = !r_b_v || ready_c;
    assign ready_a    = !r_a_v || ready_b;
    assign o_in_stall = !ready_a;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (ready_a) begin
            r_a_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a) begin
            r_a <= i_in_data;
        end
    end

    // Run accumulation.
    assign a_fire     = r_a_v && ready_b;
    assign n_count    = r_count + COUNT_W'(1);
    assign run_done   = (n_count == RUN_LEN);
    assign run_result = run_done || !r_a.pen_down;

    assign axis_ctrl.fire    = a_fire;
    assign axis_ctrl.first   = (r_count == '0);
    assign axis_ctrl.restart = run_result;

    tstm_axis u_axis_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (axis_ctrl),
        .i_sample (r_a.adc_x),
        .o_run    (run_x)
    );

    tstm_axis u_axis_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (axis_ctrl),
        .i_sample (r_a.adc_y),
        .o_run    (run_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (a_fire) begin
            r_count <= run_result ? '0 : n_count;
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
        end else begin
            if (ready_b) begin
                r_b_v <= r_a_v && run_result;
            end
            if (ready_c) begin
                r_c_v <= r_b_v;
            end
            if (ready_d) begin
                r_d_v <= r_c_v;
            end
            if (ready_e) begin
                r_e_v <= r_d_v;
            end
        end
    end

    assign mean_x = trim_mean(r_b_x);
    assign mean_y = trim_mean(r_b_y);

    always_ff @(posedge i_clk) begin
        if (ready_b) begin
            r_b_ok <= run_done;
            r_b_x  <= run_x;
            r_b_y  <= run_y;
        end
        if (ready_c) begin
            r_c_ok <= r_b_ok;
            r_c_mx <= r_b_ok ? mean_x : '0;
            r_c_my <= r_b_ok ? mean_y : '0;
        end
        if (ready_d) begin
            r_d_ok <= r_c_ok;
            r_d_mx <= r_c_mx;
            r_d_my <= r_c_my;
        end
        if (ready_e) begin
            r_e_ok <= r_d_ok;
            r_e_mx <= r_d_mx;
            r_e_my <= r_d_my;
        end
    end

    // Calibration.
    assign aff_ctrl.en_mul = ready_d;
    assign aff_ctrl.en_out = ready_e;
    assign off_x = r_c_ok ? r_offset_x : '0;
    assign off_y = r_c_ok ? r_offset_y : '0;

    tstm_affine #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_affine_x (
        .i_clk    (i_clk),
        .i_ctrl   (aff_ctrl),
        .i_gain_a (r_gain_x_ax),
        .i_gain_b (r_gain_x_ay),
        .i_offset (off_x),
        .i_avg_a  (r_c_mx),
        .i_avg_b  (r_c_my),
        .o_screen (screen_x)
    );

    tstm_affine #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_affine_y (
        .i_clk    (i_clk),
        .i_ctrl   (aff_ctrl),
        .i_gain_a (r_gain_y_ax),
        .i_gain_b (r_gain_y_ay),
        .i_offset (off_y),
        .i_avg_a  (r_c_mx),
        .i_avg_b  (r_c_my),
        .o_screen (screen_y)
    );

    assign o_out_valid         = r_e_v;
    assign o_out_data.ok       = r_e_ok;
    assign o_out_data.avg_x    = r_e_mx;
    assign o_out_data.avg_y    = r_e_my;
    assign o_out_data.screen_x = screen_x;
    assign o_out_data.screen_y = screen_y;

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < RUN_LEN)
        else $error("Run sample count reached the run length.");

    a_lift_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_fire && !r_a.pen_down) |=> (r_count == '0))
        else $error("Run did not restart after the pen lifted.");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.ok) |-> (o_out_data.avg_x == '0 &&
        o_out_data.avg_y == '0 && o_out_data.screen_x == '0 &&
        o_out_data.screen_y == '0))
        else $error("Failed run produced a nonzero result.");
`endif

endmodule

### design/tstm_axis.sv
// Per-axis run accumulator holding the sum, minimum and maximum of the current run.
module tstm_axis
    import tstm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_axis_ctrl          i_ctrl,
    input  logic [ADC_BITS-1:0] i_sample,
    output t_axis_run           o_run
);

    logic [SUM_W-1:0]    r_sum;
    logic [ADC_BITS-1:0] r_lo;
    logic [ADC_BITS-1:0] r_hi;
    t_axis_run           n_run;

    always_comb begin
        n_run.sum = (i_ctrl.first ? '0 : r_sum) + SUM_W'(i_sample);
        if (i_ctrl.first) begin
            n_run.lo = i_sample;
            n_run.hi = i_sample;
        end else begin
            n_run.lo = (i_sample < r_lo) ? i_sample : r_lo;
            n_run.hi = (i_sample > r_hi) ? i_sample : r_hi;
        end
    end

    assign o_run = n_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_lo  <= '0;
            r_hi  <= '0;
        end else if (i_ctrl.fire) begin
            if (i_ctrl.restart) begin
                r_sum <= '0;
                r_lo  <= '0;
                r_hi  <= '0;
            end else begin
                r_sum <= n_run.sum;
                r_lo  <= n_run.lo;
                r_hi  <= n_run.hi;
            end
        end
    end

endmodule

### design/tstm_affine.sv
// One affine output: registered products, then sum, truncation toward zero and saturation.
module tstm_affine
    import tstm_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_DFLT
) (
    input  logic                     i_clk,
    input  t_aff_ctrl                i_ctrl,
    input  logic signed [COEF_W-1:0] i_gain_a,
    input  logic signed [COEF_W-1:0] i_gain_b,
    input  logic signed [COEF_W-1:0] i_offset,
    input  logic [ADC_BITS-1:0]      i_avg_a,
    input  logic [ADC_BITS-1:0]      i_avg_b,
    output logic signed [SCR_W-1:0]  o_screen
);

    localparam logic signed [ACC_W-1:0] SCR_MAX_W = ACC_W'(SCR_MAX);
    localparam logic signed [ACC_W-1:0] SCR_MIN_W = ACC_W'(SCR_MIN);
    localparam logic signed [ACC_W-1:0] BIAS =
        ACC_W'((64'(1) << COEF_FRAC_BITS) - 64'(1));

    logic signed [PROD_W-1:0] r_prod_a;
    logic signed [PROD_W-1:0] r_prod_b;
    logic signed [COEF_W-1:0] r_offset;
    logic signed [SCR_W-1:0]  r_screen;
    logic signed [PROD_W-1:0] n_prod_a;
    logic signed [PROD_W-1:0] n_prod_b;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  quot;
    logic signed [SCR_W-1:0]  n_screen;

    always_comb begin
        n_prod_a = PROD_W'(i_gain_a) * PROD_W'($signed({1'b0, i_avg_a}));
        n_prod_b = PROD_W'(i_gain_b) * PROD_W'($signed({1'b0, i_avg_b}));
    end

    always_comb begin
        acc  = ACC_W'(r_prod_a) + ACC_W'(r_prod_b) + ACC_W'(r_offset);
        quot = $signed(acc + (acc[ACC_W-1] ? BIAS : '0)) >>> COEF_FRAC_BITS;
        if (quot > SCR_MAX_W) begin
            n_screen = SCR_W'(SCR_MAX);
        end else if (quot < SCR_MIN_W) begin
            n_screen = SCR_W'(SCR_MIN);
        end else begin
            n_screen = quot[SCR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_mul) begin
            r_prod_a <= n_prod_a;
            r_prod_b <= n_prod_b;
            r_offset <= i_offset;
        end
        if (i_ctrl.en_out) begin
            r_screen <= n_screen;
        end
    end

    assign o_screen = r_screen;

endmodule
